// ----- sv/sla_pkg.sv -----
// Shared types and constants for the serial line assembler.
// No dependencies; imported by sla_ctrl, sla_datapath and serial_line_assembler_unit.
package sla_pkg;

    localparam int unsigned CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_LOAD,
        ST_EMPTY
    } sla_state_t;

    // controller -> datapath
    typedef struct packed {
        logic store_wr;       // append received character (dropped when full)
        logic line_start;     // capture emit length, clear fill state
        logic rd_en;          // read store at emit index
        logic out_load_byte;  // move read character into output register
        logic out_load_empty; // load the empty-line marker
    } sla_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_newline;     // received character is a newline
        logic fill_zero;      // store holds nothing
        logic line_none;      // nothing to emit after stripping
        logic idx_last;       // emit index is on the final character
        logic out_free;       // output register may take a new result
    } sla_sts_t;

endpackage

// ----- sv/sla_ctrl.sv -----
// Controller state machine for the serial line assembler.
// Depends on sla_pkg; drives the command struct of sla_datapath.
module sla_ctrl
    import sla_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  sla_sts_t sts,
    output sla_cmd_t cmd
);

    sla_state_t state_reg;
    sla_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (!sts.in_newline) begin
                        cmd.store_wr = 1'b1;
                    end else if (!sts.fill_zero) begin
                        cmd.line_start = 1'b1;
                        state_next     = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                if (sts.line_none) begin
                    state_next = ST_EMPTY;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.out_load_byte = 1'b1;
                    state_next        = sts.idx_last ? ST_IDLE : ST_READ;
                end
            end
            ST_EMPTY: begin
                if (sts.out_free) begin
                    cmd.out_load_empty = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // never overwrite a result that has not been taken
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load_byte || cmd.out_load_empty) |-> sts.out_free)
        else $error("output register loaded while occupied");

endmodule

// ----- sv/sla_datapath.sv -----
// Datapath for the serial line assembler: line store, fill tracking, emit
// index and output register. Depends on sla_pkg; commanded by sla_ctrl.
module sla_datapath
    import sla_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CHAR_W-1:0] s_tdata,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [CHAR_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic              m_tuser,
    input  sla_cmd_t          cmd,
    output sla_sts_t          sts
);

    localparam int unsigned DEPTH  = MAX_LEN - 1;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(MAX_LEN);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [CHAR_W-1:0] store_mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic             zero_seen_reg, zero_seen_next;
    logic [CNT_W-1:0] zero_pos_reg, zero_pos_next;
    logic             last_cr_reg, last_cr_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_empty_reg, out_empty_next;

    logic             wr_ok;
    logic [CNT_W-1:0] len;

    assign wr_ok = cmd.store_wr && (fill_count_reg < DEPTH_C);
    assign len   = fill_count_reg - CNT_W'(last_cr_reg);

    // line store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            store_mem[fill_count_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_comb begin
        fill_count_next = fill_count_reg;
        zero_seen_next  = zero_seen_reg;
        zero_pos_next   = zero_pos_reg;
        last_cr_next    = last_cr_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        if (wr_ok) begin
            fill_count_next = fill_count_reg + ONE_C;
            last_cr_next    = (s_tdata == CH_RETURN);
            if (!zero_seen_reg && (s_tdata == CH_ZERO)) begin
                zero_seen_next = 1'b1;
                zero_pos_next  = fill_count_reg;
            end
        end
        if (cmd.line_start) begin
            // cut at the first zero if it lies inside the stripped line
            n_next          = (zero_seen_reg && (zero_pos_reg < len)) ? zero_pos_reg : len;
            idx_next        = '0;
            fill_count_next = '0;
            zero_seen_next  = 1'b0;
            last_cr_next    = 1'b0;
        end
        if (cmd.out_load_byte) begin
            idx_next = idx_reg + ONE_C;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load_byte) begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data_reg;
            out_last_next  = sts.idx_last;
            out_empty_next = 1'b0;
        end else if (cmd.out_load_empty) begin
            out_valid_next = 1'b1;
            out_byte_next  = CH_ZERO;
            out_last_next  = 1'b1;
            out_empty_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            zero_seen_reg  <= 1'b0;
            last_cr_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            zero_seen_reg  <= zero_seen_next;
            last_cr_reg    <= last_cr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        zero_pos_reg  <= zero_pos_next;
        n_reg         <= n_next;
        idx_reg       <= idx_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign sts.in_newline = (s_tdata == CH_NEWLINE);
    assign sts.fill_zero  = (fill_count_reg == '0);
    assign sts.line_none  = (n_reg == '0);
    assign sts.idx_last   = ((idx_reg + ONE_C) == n_reg);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= DEPTH_C)
        else $error("fill count beyond store depth");

    a_zero_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        zero_seen_reg |-> (zero_pos_reg < fill_count_reg))
        else $error("first zero position outside stored characters");

    a_read_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (idx_reg < n_reg))
        else $error("store read beyond emitted line");

    a_empty_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load_empty |=> (m_tvalid && m_tlast && m_tuser))
        else $error("empty-line marker not presented as final result");

endmodule

// ----- sv/serial_line_assembler_unit.sv -----
// Top level of the serial line assembler: newline-delimited line framer.
// Depends on sla_pkg, sla_ctrl and sla_datapath.
//
//  channel | dir | tdata          | tlast      | tuser
//  --------+-----+----------------+------------+-----------
//  s_      | in  | rx_byte [7:0]  | -          | -
//  m_      | out | line_byte[7:0] | line_last  | line_empty
//
// Sequence: a character that is not a newline is stored in the cycle of its
//   transfer (dropped when the store is full); the block stays ready for the
//   next one straight away. A newline on an empty line is taken and dropped.
// A newline on a non-empty line holds input off while the line is emitted:
//   its transfer fixes the emit length, the calc state reads the first
//   character, then each character takes an output register load and all but
//   the last a further store read, set by the single registered read port of
//   the line store; an empty result takes the calc state and a marker load.
// Reset (aresetn low, synchronous) clears the fill count and output valid;
//   the store contents are left as they are and are never read unwritten.
// Stalls: m_tready low holds the current result; input resumes once the last
//   result is in the output register, even if it has not yet been taken.
module serial_line_assembler_unit
    import sla_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    // received characters
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] rx_byte
    // assembled line
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] line_byte
    output logic              m_tlast,   // line_last
    output logic              m_tuser    // [0] line_empty
);

    sla_cmd_t cmd;
    sla_sts_t sts;

    // sequencing: store on character, emit on newline
    sla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // line store, CR / zero tracking, output register
    sla_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ----- dv/serial_line_assembler_unit_tb.sv -----
// Self-checking bench for serial_line_assembler_unit: line framing, CR strip,
// zero-byte cut and truncation, checked against an in-bench line predictor.
// Depends on sla_pkg and serial_line_assembler_unit.
module serial_line_assembler_unit_tb
    import sla_pkg::*;
;

    localparam int unsigned MAX_LEN    = 64;
    localparam int unsigned LINE_CAP   = MAX_LEN - 1;  // characters kept per line
    localparam int unsigned HOLD_LEN   = 120;          // long receiver hold-off
    localparam int unsigned WDOG_LIMIT = 4000;         // cycles with no transfer
    localparam int unsigned RAND_ITEMS = 460;
    localparam int unsigned CALM_FROM  = 380;          // no idling beyond this

    // one expected result on the line channel
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              empty;
    } line_beat_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [CHAR_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    // stimulus and predictor state
    logic [CHAR_W-1:0] chars_pending[$];
    line_beat_t        beats_due[$];
    logic [CHAR_W-1:0] line_buf[LINE_CAP];
    int unsigned       line_fill    = 0;
    int unsigned       chars_queued = 0;
    int unsigned       chars_sent   = 0;
    int unsigned       lines_framed = 0;
    int unsigned       lines_cut    = 0;
    int unsigned       beats_seen   = 0;
    int unsigned       fail_count   = 0;

    // phase control, written by the sequencer only
    logic quiet    = 1'b0;
    logic hold_arm = 1'b0;

    int unsigned src_gap   = 0;
    int unsigned sink_gap  = 0;
    int unsigned hold_cnt  = 0;
    logic        hold_done = 1'b0;
    int unsigned idle_cyc  = 0;

    always #5 aclk = ~aclk;

    serial_line_assembler_unit #(
        .MAX_LEN (MAX_LEN)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] rx_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] line_byte
        .m_tlast  (m_tlast),   // line_last
        .m_tuser  (m_tuser)    // [0] line_empty
    );

    // Line predictor: applied to every character the block takes. Anything but
    // a newline is stored while there is room; a newline on a non-empty store
    // frames the line (one trailing CR stripped, cut at the first zero byte).
    task automatic frame_char(input logic [CHAR_W-1:0] ch);
        int unsigned keep;
        int unsigned n;
        line_beat_t  b;
        if (ch != CH_NEWLINE) begin
            if (line_fill < LINE_CAP) begin
                line_buf[line_fill] = ch;
                line_fill++;
            end else begin
                lines_cut += (line_fill == LINE_CAP) ? 1 : 0;
                line_fill = LINE_CAP + 1;  // marks this line as already counted as cut
            end
            return;
        end
        if (line_fill > LINE_CAP)
            line_fill = LINE_CAP;
        if (line_fill == 0)
            return;
        keep = line_fill;
        if (line_buf[keep-1] == CH_RETURN)
            keep--;
        n = 0;
        while (n < keep && line_buf[n] != CH_ZERO)
            n++;
        line_fill = 0;
        lines_framed++;
        if (n == 0) begin
            b = '{ch: '0, last: 1'b1, empty: 1'b1};
            beats_due.push_back(b);
            return;
        end
        for (int unsigned i = 0; i < n; i++) begin
            b = '{ch: line_buf[i], last: (i + 1 == n), empty: 1'b0};
            beats_due.push_back(b);
        end
    endtask

    // Driver: one transfer per handshake, random bursts of idling after a
    // transfer unless the run is in its calm tail.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                frame_char(s_tdata);
                chars_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // block is busy emitting; keep the character on offer
            end else if (src_gap > 0) begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (chars_pending.size() > 0) begin
                s_tdata  <= chars_pending.pop_front();
                s_tvalid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    src_gap <= $urandom_range(1, 13);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver: check each result transfer against the oldest
    // expectation, then decide readiness (long hold-off, stall bursts).
    always @(posedge aclk) begin
        line_beat_t exp_beat;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
            hold_cnt <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_seen++;
                if (beats_due.size() == 0) begin
                    $error("unexpected result: line_byte=%0h last=%0b empty=%0b",
                           m_tdata, m_tlast, m_tuser);
                    fail_count++;
                end else begin
                    exp_beat = beats_due.pop_front();
                    if (m_tdata !== exp_beat.ch) begin
                        $error("line_byte: expected %0h, got %0h", exp_beat.ch, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== exp_beat.last) begin
                        $error("line_last: expected %0b, got %0b", exp_beat.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== exp_beat.empty) begin
                        $error("line_empty: expected %0b, got %0b", exp_beat.empty, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (hold_arm && !hold_done) begin
                hold_done <= 1'b1;
                hold_cnt  <= HOLD_LEN;
                m_tready  <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 12);  // start a receiver stall burst of random length
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any stretch without a transfer on either side beyond the
    // limit means the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= WDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    task automatic queue_chars(input logic [CHAR_W-1:0] chs[]);
        foreach (chs[i]) begin
            chars_pending.push_back(chs[i]);
            chars_queued++;
        end
    endtask

    // One random line: mostly short, now and then past the store's capacity;
    // stray CRs and zero bytes mixed in, sometimes a trailing CR.
    task automatic queue_rand_line();
        int unsigned       len;
        logic [CHAR_W-1:0] ch;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 75) : $urandom_range(0, 12);
        for (int unsigned i = 0; i < len; i++) begin
            case ($urandom_range(0, 15))
                0: ch = CH_ZERO;
                1: ch = CH_RETURN;
                default: begin
                    do ch = CHAR_W'($urandom_range(0, 255)); while (ch == CH_NEWLINE);
                end
            endcase
            chars_pending.push_back(ch);
        end
        if ($urandom_range(0, 3) == 0) begin
            chars_pending.push_back(CH_RETURN);
            len++;
        end
        chars_pending.push_back(CH_NEWLINE);
        chars_queued += len + 1;
    endtask

    // Sender pause: wait until every queued character has been taken and
    // every expected result has come, then a short settle.
    task automatic wait_drained();
        while (chars_pending.size() > 0 || s_tvalid || beats_due.size() > 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Sequencer: all queue and phase updates happen on the falling edge so
    // the clocked processes never race with them.
    initial begin
        logic [CHAR_W-1:0] long_line[];
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: newline on empty store, byte extremes, zero byte first,
        // lone CR, double CR, CR mid-line, zero mid-line, trailing CR strip
        queue_chars('{CH_NEWLINE});
        queue_chars('{8'hFF, CH_NEWLINE});
        queue_chars('{CH_ZERO, CH_NEWLINE});
        queue_chars('{CH_RETURN, CH_NEWLINE});
        queue_chars('{CH_RETURN, CH_RETURN, CH_NEWLINE});
        queue_chars('{8'h61, CH_RETURN, 8'h62, CH_NEWLINE});
        queue_chars('{8'h61, 8'h62, CH_ZERO, 8'h63, 8'h64, CH_NEWLINE});
        queue_chars('{8'h01, 8'h80, 8'h7F, CH_RETURN, CH_NEWLINE});
        wait_drained();

        // receiver holds off while a short line and a store-overflowing line
        // are offered, so input stalls behind the pending results
        hold_arm = 1'b1;
        queue_chars('{8'h41, 8'h42, 8'h43, 8'h44, 8'h45, CH_NEWLINE});
        long_line = new[LINE_CAP + 8];
        foreach (long_line[i])
            long_line[i] = 8'h20 + i[6:0];
        queue_chars(long_line);
        queue_chars('{CH_NEWLINE});
        wait_drained();

        // random lines, with idling, then a calm tail without it
        while (chars_queued < CALM_FROM)
            queue_rand_line();
        wait_drained();
        quiet = 1'b1;
        while (chars_queued < RAND_ITEMS)
            queue_rand_line();
        wait_drained();
        repeat (20) @(negedge aclk);

        if (beats_due.size() != 0) begin
            $error("%0d expected results never arrived", beats_due.size());
            fail_count++;
        end
        $display("%0d characters sent, %0d lines framed (%0d truncated), %0d results checked",
                 chars_sent, lines_framed, lines_cut, beats_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
sv/sla_pkg.sv
sv/sla_ctrl.sv
sv/sla_datapath.sv
sv/serial_line_assembler_unit.sv
dv/serial_line_assembler_unit_tb.sv
